/* design/mfba_pkg.sv */
// ----------------------------------------------------------------------------
// mfba_pkg : shared types and constants for the max flow engine
// State encoding, item kind codes, status codes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package mfba_pkg;

    // Item kinds carried on s_tuser
    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_RUN  = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    // Result status carried on m_tuser
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_SAME_END = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_VERTEX_COUNT = 2'd0;
    localparam logic [1:0] CFG_SOURCE       = 2'd1;
    localparam logic [1:0] CFG_SINK         = 2'd2;

    localparam int FLOW_BITS = 24;

    typedef enum logic [4:0] {
        ST_CLR,
        ST_IDLE,
        ST_RD_WAIT,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_CHECK,
        ST_BFS_INIT,
        ST_BFS_POP,
        ST_BFS_POPW,
        ST_BFS_SCAN,
        ST_BFS_CHK,
        ST_BN_STEP,
        ST_BN_PAR,
        ST_BN_RES,
        ST_AU_STEP,
        ST_AU_PAR,
        ST_AU_FWD,
        ST_AU_BWD
    } state_t;

endpackage

`default_nettype wire

/* design/max_flow_bfs_augment.sv */
// ----------------------------------------------------------------------------
// max_flow_bfs_augment : max flow by breadth-first augmenting paths
// Dense capacity matrix in block memory, one residual/flow update per step
// under a small sequencer.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  s_       | s_tvalid/s_tready  | s_tuser kind, s_tdata row, col, capacity
//  m_       | m_tvalid/m_tready  | m_tuser status, m_tdata value
//  cfg_     | cfg_we             | cfg_addr register index, cfg_wdata value
//
//  After reset a clearing pass over all CELLS cells (256 at 16 vertices) zeroes the
//  capacity and flow memories; no item is taken meanwhile.
//  Read results come from a registered flow memory read. Each memory has one
//  read and one write port. Run: copy capacities to residuals cell by cell, then
//  per search pop vertices and scan neighbours (visited ones skipped, unvisited
//  ones checked for residual), walk the path for the bottleneck, then augment it.
//  The input waits while a run is busy or the result register is still held.
// ----------------------------------------------------------------------------
`default_nettype none

module max_flow_bfs_augment
    import mfba_pkg::*;
#(
    parameter int MAX_VERTICES  = 16,
    parameter int CAPACITY_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [4:0]  cfg_wdata,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // row[3:0], col[7:4], capacity_value[23:8]
    input  wire logic [1:0]  s_tuser,   // kind[1:0]
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // value[23:0]
    output logic             m_tuser    // status[0]
);

    localparam int VB    = $clog2(MAX_VERTICES);
    localparam int CA    = 2 * VB;
    localparam int CELLS = 1 << CA;
    localparam int CW    = (VB + 1 > 5) ? VB + 1 : 5;
    localparam int RB    = CAPACITY_BITS + 1;
    localparam int FB    = FLOW_BITS;

    // ---------------- registers ----------------
    state_t            state_reg, state_next;
    logic [CA-1:0]     cnt_reg, cnt_next;
    logic [VB-1:0]     u_reg, u_next;
    logic [CW-1:0]     v_reg, v_next;
    logic [CW-1:0]     head_reg, head_next;
    logic [CW-1:0]     tail_reg, tail_next;
    logic [MAX_VERTICES-1:0] visited_reg, visited_next;
    logic [RB-1:0]     pf_reg, pf_next;
    logic [FB-1:0]     total_reg, total_next;
    logic              rd_in_reg, rd_in_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [FB-1:0]     m_value_reg, m_value_next;
    logic              m_status_reg, m_status_next;
    logic [4:0]        vcount_reg;
    logic [3:0]        source_reg;
    logic [3:0]        sink_reg;

    // ---------------- memory ports ----------------
    logic                     cap_we;
    logic [CA-1:0]            cap_waddr, cap_raddr;
    logic [CAPACITY_BITS-1:0] cap_wdata, cap_rdata;
    logic                     res_we;
    logic [CA-1:0]            res_waddr, res_raddr;
    logic [RB-1:0]            res_wdata, res_rdata;
    logic                     flow_we;
    logic [CA-1:0]            flow_waddr, flow_raddr;
    logic [FB-1:0]            flow_wdata, flow_rdata;
    logic                     par_we;
    logic [VB-1:0]            par_waddr, par_raddr, par_wdata, par_rdata;
    logic                     q_we;
    logic [VB-1:0]            q_waddr, q_raddr, q_wdata, q_rdata;

    logic [CAPACITY_BITS-1:0] cap_mem  [CELLS];
    logic [RB-1:0]            res_mem  [CELLS];
    logic [FB-1:0]            flow_mem [CELLS];
    logic [VB-1:0]            par_mem  [MAX_VERTICES];
    logic [VB-1:0]            q_mem    [MAX_VERTICES];

    // ---------------- decoded inputs ----------------
    logic [CW-1:0] row_w, col_w, s_w, t_w, n_w;
    logic [VB-1:0] s_v, t_v, v_v;
    logic          in_inside, accept;
    logic [CA-1:0] in_addr;
    logic [31:0]   cap_ext;
    logic [FB:0]   flow_sum, total_sum;
    logic [FB-1:0] flow_sat, total_sat;

    assign row_w     = CW'(s_tdata[3:0]);
    assign col_w     = CW'(s_tdata[7:4]);
    assign in_inside = (row_w < CW'(MAX_VERTICES)) && (col_w < CW'(MAX_VERTICES));
    assign in_addr   = {row_w[VB-1:0], col_w[VB-1:0]};
    assign cap_ext   = {16'd0, s_tdata[23:8]};
    assign s_w       = CW'(source_reg);
    assign t_w       = CW'(sink_reg);
    assign s_v       = s_w[VB-1:0];
    assign t_v       = t_w[VB-1:0];
    assign v_v       = v_reg[VB-1:0];
    assign n_w       = (CW'(vcount_reg) > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES)
                                                           : CW'(vcount_reg);
    assign accept    = s_tvalid && s_tready;

    // saturating adders for edge flow and total
    assign flow_sum  = {1'b0, flow_rdata} + (FB + 1)'(pf_reg);
    assign flow_sat  = flow_sum[FB] ? {FB{1'b1}} : flow_sum[FB-1:0];
    assign total_sum = {1'b0, total_reg} + (FB + 1)'(pf_reg);
    assign total_sat = total_sum[FB] ? {FB{1'b1}} : total_sum[FB-1:0];

    // ---------------- configuration registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg <= 5'd16;
            source_reg <= 4'd0;
            sink_reg   <= 4'd15;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_VERTEX_COUNT: vcount_reg <= cfg_wdata;
                CFG_SOURCE:       source_reg <= cfg_wdata[3:0];
                CFG_SINK:         sink_reg   <= cfg_wdata[3:0];
                default:          ;
            endcase
        end
    end

    // ---------------- memories ----------------
    always_ff @(posedge aclk) begin
        if (cap_we) cap_mem[cap_waddr] <= cap_wdata;
        cap_rdata <= cap_mem[cap_raddr];
    end

    always_ff @(posedge aclk) begin
        if (res_we) res_mem[res_waddr] <= res_wdata;
        res_rdata <= res_mem[res_raddr];
    end

    always_ff @(posedge aclk) begin
        if (flow_we) flow_mem[flow_waddr] <= flow_wdata;
        flow_rdata <= flow_mem[flow_raddr];
    end

    always_ff @(posedge aclk) begin
        if (par_we) par_mem[par_waddr] <= par_wdata;
        par_rdata <= par_mem[par_raddr];
    end

    always_ff @(posedge aclk) begin
        if (q_we) q_mem[q_waddr] <= q_wdata;
        q_rdata <= q_mem[q_raddr];
    end

    // ---------------- state and datapath registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLR;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            visited_reg  <= '0;
            total_reg    <= '0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            visited_reg  <= visited_next;
            total_reg    <= total_next;
        end
        u_reg        <= u_next;
        v_reg        <= v_next;
        head_reg     <= head_next;
        tail_reg     <= tail_next;
        pf_reg       <= pf_next;
        rd_in_reg    <= rd_in_next;
        m_value_reg  <= m_value_next;
        m_status_reg <= m_status_next;
    end

    // ---------------- sequencer ----------------
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        u_next        = u_reg;
        v_next        = v_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        visited_next  = visited_reg;
        pf_next       = pf_reg;
        total_next    = total_reg;
        rd_in_next    = rd_in_reg;
        m_value_next  = m_value_reg;
        m_status_next = m_status_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        s_tready      = 1'b0;

        cap_we = 1'b0;  cap_waddr = in_addr;  cap_wdata = cap_ext[CAPACITY_BITS-1:0];
        cap_raddr = cnt_reg;
        res_we = 1'b0;  res_waddr = {u_reg, v_v};  res_wdata = '0;
        res_raddr = {u_reg, v_v};
        flow_we = 1'b0; flow_waddr = cnt_reg; flow_wdata = '0;
        flow_raddr = in_addr;
        par_we = 1'b0;  par_waddr = v_v;  par_wdata = u_reg;  par_raddr = v_v;
        q_we = 1'b0;    q_waddr = tail_reg[VB-1:0];  q_wdata = v_v;
        q_raddr = head_reg[VB-1:0];

        unique case (state_reg)
            // zero capacity and flow memories after reset
            ST_CLR: begin
                cap_we    = 1'b1;
                cap_waddr = cnt_reg;
                cap_wdata = '0;
                flow_we   = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == {CA{1'b1}}) state_next = ST_IDLE;
            end

            ST_IDLE: begin
                s_tready = !m_tvalid_reg || m_tready;
                if (accept) begin
                    case (s_tuser)
                        KIND_LOAD: cap_we = in_inside;
                        KIND_RUN: begin
                            cnt_next   = '0;
                            total_next = '0;
                            state_next = ST_COPY_RD;
                        end
                        KIND_READ: begin
                            rd_in_next = in_inside;
                            state_next = ST_RD_WAIT;
                        end
                        default: ;
                    endcase
                end
            end

            ST_RD_WAIT: begin
                m_tvalid_next = 1'b1;
                m_value_next  = rd_in_reg ? flow_rdata : '0;
                m_status_next = STATUS_OK;
                state_next    = ST_IDLE;
            end

            // residual := capacity, flow := 0
            ST_COPY_RD: state_next = ST_COPY_WR;

            ST_COPY_WR: begin
                res_we     = 1'b1;
                res_waddr  = cnt_reg;
                res_wdata  = {1'b0, cap_rdata};
                flow_we    = 1'b1;
                cnt_next   = cnt_reg + 1'b1;
                state_next = (cnt_reg == {CA{1'b1}}) ? ST_CHECK : ST_COPY_RD;
            end

            ST_CHECK: begin
                if (s_w == t_w) begin
                    m_tvalid_next = 1'b1;
                    m_value_next  = '0;
                    m_status_next = STATUS_SAME_END;
                    state_next    = ST_IDLE;
                end else if (s_w >= n_w || t_w >= n_w) begin
                    m_tvalid_next = 1'b1;
                    m_value_next  = '0;
                    m_status_next = STATUS_OK;
                    state_next    = ST_IDLE;
                end else begin
                    state_next = ST_BFS_INIT;
                end
            end

            // start a search from the source
            ST_BFS_INIT: begin
                visited_next      = '0;
                visited_next[s_v] = 1'b1;
                q_we       = 1'b1;
                q_waddr    = '0;
                q_wdata    = s_v;
                par_we     = 1'b1;
                par_waddr  = s_v;
                par_wdata  = s_v;
                head_next  = '0;
                tail_next  = CW'(1);
                state_next = ST_BFS_POP;
            end

            ST_BFS_POP: begin
                if (head_reg < tail_reg) begin
                    state_next = ST_BFS_POPW;
                end else if (visited_reg[t_v]) begin
                    pf_next    = {RB{1'b1}};
                    v_next     = t_w;
                    state_next = ST_BN_STEP;
                end else begin
                    m_tvalid_next = 1'b1;
                    m_value_next  = total_reg;
                    m_status_next = STATUS_OK;
                    state_next    = ST_IDLE;
                end
            end

            ST_BFS_POPW: begin
                u_next     = q_rdata;
                head_next  = head_reg + 1'b1;
                v_next     = '0;
                state_next = ST_BFS_SCAN;
            end

            // scan neighbors in ascending order
            ST_BFS_SCAN: begin
                if (v_reg >= n_w) begin
                    state_next = ST_BFS_POP;
                end else if (visited_reg[v_v]) begin
                    v_next = v_reg + 1'b1;
                end else begin
                    state_next = ST_BFS_CHK;
                end
            end

            ST_BFS_CHK: begin
                if (res_rdata != '0) begin
                    if (tail_reg < CW'(MAX_VERTICES)) begin
                        q_we      = 1'b1;
                        tail_next = tail_reg + 1'b1;
                    end
                    par_we            = 1'b1;
                    visited_next[v_v] = 1'b1;
                end
                v_next     = v_reg + 1'b1;
                state_next = ST_BFS_SCAN;
            end

            // bottleneck along the parent path
            ST_BN_STEP: begin
                if (v_v == s_v) begin
                    v_next     = t_w;
                    state_next = ST_AU_STEP;
                end else begin
                    state_next = ST_BN_PAR;
                end
            end

            ST_BN_PAR: begin
                u_next     = par_rdata;
                res_raddr  = {par_rdata, v_v};
                state_next = ST_BN_RES;
            end

            ST_BN_RES: begin
                if (res_rdata < pf_reg) pf_next = res_rdata;
                v_next     = CW'(u_reg);
                state_next = ST_BN_STEP;
            end

            // augment along the path
            ST_AU_STEP: begin
                if (v_v == s_v) begin
                    total_next = total_sat;
                    state_next = ST_BFS_INIT;
                end else begin
                    state_next = ST_AU_PAR;
                end
            end

            ST_AU_PAR: begin
                u_next     = par_rdata;
                res_raddr  = {par_rdata, v_v};
                flow_raddr = {par_rdata, v_v};
                state_next = ST_AU_FWD;
            end

            ST_AU_FWD: begin
                res_we     = 1'b1;
                res_waddr  = {u_reg, v_v};
                res_wdata  = res_rdata - pf_reg;
                flow_we    = 1'b1;
                flow_waddr = {u_reg, v_v};
                flow_wdata = flow_sat;
                res_raddr  = {v_v, u_reg};
                state_next = ST_AU_BWD;
            end

            ST_AU_BWD: begin
                res_we     = 1'b1;
                res_waddr  = {v_v, u_reg};
                res_wdata  = res_rdata + pf_reg;
                v_next     = CW'(u_reg);
                state_next = ST_AU_STEP;
            end

            default: state_next = ST_IDLE;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_value_reg;
    assign m_tuser  = m_status_reg;

    // ---------------- assertions ----------------
    a_no_take_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLR) |-> !s_tready)
        else $error("item taken during clearing pass");

    a_same_end_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == STATUS_SAME_END) |-> (source_reg == sink_reg))
        else $error("same-end status with distinct source and sink");

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BFS_SCAN || state_reg == ST_BFS_CHK)
            |-> (tail_reg <= CW'(MAX_VERTICES) && head_reg <= tail_reg))
        else $error("search queue pointers out of bounds");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_AU_FWD) |-> (res_rdata >= pf_reg))
        else $error("residual below bottleneck");

    a_result_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("held result dropped");

endmodule

`default_nettype wire
